// ===== sv/amf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter package
// Shared constants, types and address helpers for the filter's modules.
// ----------------------------------------------------------------------------
package amf_pkg;

    localparam int MAX_WINDOW  = 7;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int HALF        = MAX_WINDOW / 2;
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WIN_N       = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_W       = $clog2(WIN_N + 1);
    localparam int MAX_GEOM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int POS_W       = $clog2(MAX_GEOM + 1);
    localparam int PEND_W      = $clog2(HALF * MAX_WIDTH + HALF + 2);
    localparam int S_W         = $clog2(MAX_WINDOW + 3);
    localparam int PIX_W       = 8;
    localparam int SIDE_W      = 3;
    localparam int GEOM_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QDEPTH      = 2;

    // Input command carried in tuser.
    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

    // Configuration as seen by the front and back (geometry already clamped).
    typedef struct packed {
        logic [SIDE_W-1:0] win_min;
        logic [SIDE_W-1:0] win_max;
        logic [POS_W-1:0]  width;
        logic [POS_W-1:0]  height;
    } cfg_t;

    // One filter job handed from the front to the back.
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } job_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CENTRE,
        BK_SETUP,
        BK_CORNER,
        BK_SCAN,
        BK_DRAIN,
        BK_SELECT,
        BK_DECIDE,
        BK_OUTPUT
    } bk_state_t;

    // Circular store address plus an offset below the store depth.
    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(STORE_DEPTH))
            s = s - (ADDR_W+1)'(STORE_DEPTH);
        return s[ADDR_W-1:0];
    endfunction

    // Circular store address minus an offset below the store depth.
    function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        if (a >= b)
            s = {1'b0, a} - {1'b0, b};
        else
            s = {1'b0, a} + (ADDR_W+1)'(STORE_DEPTH) - {1'b0, b};
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/amf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module amf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/amf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter front end
// Accepts push and flush transactions, writes pixels into the line store and
// issues one filter job for every pixel whose window is complete.
// ----------------------------------------------------------------------------
module amf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  amf_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [amf_pkg::PIX_W-1:0]   s_tdata,
    input  logic                        s_tuser,
    output logic                        wr_en,
    output logic [amf_pkg::ADDR_W-1:0]  wr_addr,
    output logic [amf_pkg::PIX_W-1:0]   wr_data,
    output logic                        q_push,
    output amf_pkg::job_t               q_job,
    input  logic                        q_full,
    input  logic                        q_empty,
    input  logic                        back_busy
);
    import amf_pkg::*;

    logic [POS_W-1:0]  in_row_reg, in_row_next;
    logic [POS_W-1:0]  in_col_reg, in_col_next;
    logic [POS_W-1:0]  out_row_reg, out_row_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next;
    logic [ADDR_W-1:0] in_addr_reg, in_addr_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              in_done_reg, in_done_next;
    logic [PEND_W-1:0] lag;
    logic              is_flush;
    logic              accept;
    logic [POS_W-1:0]  oc, orow;
    logic              last;

    // Distance in pixels between the newest push and the next output.
    assign lag = PEND_W'(cfg.width) * PEND_W'(HALF) + PEND_W'(HALF);

    // Store writes wait until the back end holds no job, flushes only for room.
    assign is_flush = (cmd_t'(s_tuser) == CMD_FLUSH);
    assign s_tready = !q_full && (is_flush || (q_empty && !back_busy));
    assign accept   = s_tvalid && s_tready;

    assign wr_addr = in_addr_reg;
    assign wr_data = s_tdata;

    // Position counters and job issue.
    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        in_addr_next  = in_addr_reg;
        out_addr_next = out_addr_reg;
        pend_next     = pend_reg;
        in_done_next  = in_done_reg;
        wr_en         = 1'b0;
        q_push        = 1'b0;
        oc            = out_col_reg + POS_W'(1);
        orow          = out_row_reg;
        last          = 1'b0;

        if (accept)
        begin
            if (is_flush)
            begin
                q_push = in_done_reg;
            end
            else if (!in_done_reg)
            begin
                wr_en        = 1'b1;
                in_addr_next = addr_add(in_addr_reg, ADDR_W'(1));
                in_col_next  = in_col_reg + POS_W'(1);
                if (in_col_next >= cfg.width)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + POS_W'(1);
                end
                if (in_row_next >= cfg.height)
                    in_done_next = 1'b1;
                pend_next = pend_reg + PEND_W'(1);
                q_push    = (pend_next > lag);
            end
        end

        if (q_push)
        begin
            if (oc >= cfg.width)
            begin
                oc   = '0;
                orow = out_row_reg + POS_W'(1);
            end
            last          = (orow >= cfg.height);
            out_col_next  = oc;
            out_row_next  = orow;
            out_addr_next = addr_add(out_addr_reg, ADDR_W'(1));
            pend_next     = pend_next - PEND_W'(1);
            if (last)
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                out_row_next  = '0;
                out_col_next  = '0;
                in_addr_next  = '0;
                out_addr_next = '0;
                pend_next     = '0;
                in_done_next  = 1'b0;
            end
        end

        q_job.row  = out_row_reg;
        q_job.col  = out_col_reg;
        q_job.addr = out_addr_reg;
        q_job.last = last;
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            in_addr_reg  <= '0;
            out_addr_reg <= '0;
            pend_reg     <= '0;
            in_done_reg  <= 1'b0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            in_addr_reg  <= in_addr_next;
            out_addr_reg <= out_addr_next;
            pend_reg     <= pend_next;
            in_done_reg  <= in_done_next;
        end
    end

    // A job never enters a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job issued into a full queue");

    // The store is written only while no job is queued or being filtered.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (q_empty && !back_busy))
        else $error("line store written while a job is pending");

endmodule

// ===== sv/amf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter job queue
// Short FIFO of filter jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module amf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  amf_pkg::job_t push_job,
    input  logic          pop,
    output amf_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);
    import amf_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    job_t               slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            count_next  = count_next + (PTR_W+1)'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - (PTR_W+1)'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // Fill count stays within the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QDEPTH))
        else $error("queue fill count out of range");

endmodule

// ===== sv/amf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter back end
// Reads each job's window from the line store, finds min, max and median,
// grows the window when needed and holds the result in an output register.
// ----------------------------------------------------------------------------
module amf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  amf_pkg::cfg_t               cfg,
    input  logic                        q_empty,
    input  amf_pkg::job_t               q_job,
    output logic                        q_pop,
    output logic                        busy,
    output logic                        rd_en,
    output logic [amf_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [amf_pkg::PIX_W-1:0]   rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [amf_pkg::PIX_W-1:0]   m_tdata,
    output logic                        m_tlast
);
    import amf_pkg::*;

    bk_state_t          state_reg, state_next;
    job_t               job_reg, job_next;
    logic [PIX_W-1:0]   centre_reg, centre_next;
    logic [S_W-1:0]     side_reg, side_next;
    logic [POS_W-1:0]   r0_win, r1_reg, r1_next;
    logic [POS_W-1:0]   c0_reg, c0_next, c1_reg, c1_next;
    logic [POS_W-1:0]   ii_reg, ii_next, jj_reg, jj_next;
    logic [ADDR_W-1:0]  row_addr_reg, row_addr_next;
    logic [ADDR_W-1:0]  cur_addr_reg, cur_addr_next;
    logic [POS_W-1:0]   back_reg, back_next;
    logic               pipe_vld_reg;
    logic [PIX_W-1:0]   vals_reg [WIN_N];
    logic [WIN_N-1:0]   vld_reg;
    logic [WIN_N-1:0]   le_reg, le_next;
    logic [CNT_W-1:0]   n_reg;
    logic [PIX_W-1:0]   lo_reg, hi_reg;
    logic [PIX_W-1:0]   ans_reg, ans_next;
    logic [2:0]         bit_reg, bit_next;
    logic               phase_reg, phase_next;
    logic [PIX_W-1:0]   res_reg, res_next;
    logic               clear_win;
    logic               load_out;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_last_reg;
    logic [POS_W-1:0]   half_side;
    logic [PIX_W-1:0]   thresh;
    logic [CNT_W-1:0]   le_cnt;
    logic [ADDR_W-1:0]  next_row_addr;

    // Upper end of a clipped span.
    function automatic logic [POS_W-1:0] span_hi(input logic [POS_W-1:0] ctr,
                                                 input logic [POS_W-1:0] h,
                                                 input logic [POS_W-1:0] lim);
        logic [POS_W:0] b;
        b = {1'b0, ctr} + {1'b0, h};
        if (b > ({1'b0, lim} - (POS_W+1)'(1)))
            b = {1'b0, lim} - (POS_W+1)'(1);
        return b[POS_W-1:0];
    endfunction

    // Lower end of a clipped span, never above the upper end.
    function automatic logic [POS_W-1:0] span_lo(input logic [POS_W-1:0] ctr,
                                                 input logic [POS_W-1:0] h,
                                                 input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] a;
        a = (ctr >= h) ? ctr - h : '0;
        if (a > hi)
            a = hi;
        return a;
    endfunction

    assign busy      = (state_reg != BK_IDLE);
    assign half_side = POS_W'(side_reg >> 1);
    assign thresh    = ans_reg | ((PIX_W'(1) << bit_reg) - PIX_W'(1));
    assign next_row_addr = addr_add(row_addr_reg, ADDR_W'(cfg.width));

    // Count of window pixels at or below the current threshold.
    always_comb
    begin
        le_cnt = '0;
        for (int k = 0; k < WIN_N; k++)
            le_cnt = le_cnt + CNT_W'(le_reg[k]);
    end

    // Sequencer: next state and datapath controls.
    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        centre_next   = centre_reg;
        side_next     = side_reg;
        r0_win        = '0;
        r1_next       = r1_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        ii_next       = ii_reg;
        jj_next       = jj_reg;
        row_addr_next = row_addr_reg;
        cur_addr_next = cur_addr_reg;
        back_next     = back_reg;
        le_next       = le_reg;
        ans_next      = ans_reg;
        bit_next      = bit_reg;
        phase_next    = phase_reg;
        res_next      = res_reg;
        clear_win     = 1'b0;
        load_out      = 1'b0;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = cur_addr_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    rd_en      = 1'b1;
                    rd_addr    = q_job.addr;
                    side_next  = (S_W'(cfg.win_min) > S_W'(MAX_WINDOW)) ?
                                 S_W'(MAX_WINDOW) : S_W'(cfg.win_min);
                    state_next = BK_CENTRE;
                end
            end

            BK_CENTRE:
            begin
                centre_next = rd_data;
                state_next  = BK_SETUP;
            end

            // Clip the window and start the walk back to its top-left corner.
            BK_SETUP:
            begin
                r1_next       = span_hi(job_reg.row, half_side, cfg.height);
                r0_win        = span_lo(job_reg.row, half_side, r1_next);
                c1_next       = span_hi(job_reg.col, half_side, cfg.width);
                c0_next       = span_lo(job_reg.col, half_side, c1_next);
                ii_next       = r0_win;
                jj_next       = c0_next;
                back_next     = job_reg.row - r0_win;
                cur_addr_next = addr_sub(job_reg.addr, ADDR_W'(job_reg.col - c0_next));
                clear_win     = 1'b1;
                state_next    = BK_CORNER;
            end

            // One row back per cycle.
            BK_CORNER:
            begin
                if (back_reg != '0)
                begin
                    cur_addr_next = addr_sub(cur_addr_reg, ADDR_W'(cfg.width));
                    back_next     = back_reg - POS_W'(1);
                end
                else
                begin
                    row_addr_next = cur_addr_reg;
                    state_next    = BK_SCAN;
                end
            end

            // One store read per cycle over the window, row by row.
            BK_SCAN:
            begin
                rd_en = 1'b1;
                if (jj_reg == c1_reg)
                begin
                    if (ii_reg == r1_reg)
                    begin
                        state_next = BK_DRAIN;
                    end
                    else
                    begin
                        ii_next       = ii_reg + POS_W'(1);
                        jj_next       = c0_reg;
                        row_addr_next = next_row_addr;
                        cur_addr_next = next_row_addr;
                    end
                end
                else
                begin
                    jj_next       = jj_reg + POS_W'(1);
                    cur_addr_next = addr_add(cur_addr_reg, ADDR_W'(1));
                end
            end

            BK_DRAIN:
            begin
                ans_next   = '0;
                bit_next   = 3'd7;
                phase_next = 1'b0;
                state_next = BK_SELECT;
            end

            // Median search, one bit at a time: compare, then count.
            BK_SELECT:
            begin
                if (!phase_reg)
                begin
                    for (int k = 0; k < WIN_N; k++)
                        le_next[k] = vld_reg[k] && (vals_reg[k] <= thresh);
                    phase_next = 1'b1;
                end
                else
                begin
                    if (!(le_cnt > (n_reg >> 1)))
                        ans_next = ans_reg | (PIX_W'(1) << bit_reg);
                    phase_next = 1'b0;
                    if (bit_reg == 3'd0)
                        state_next = BK_DECIDE;
                    else
                        bit_next = bit_reg - 3'd1;
                end
            end

            BK_DECIDE:
            begin
                if (lo_reg < ans_reg && ans_reg < hi_reg)
                begin
                    res_next   = (lo_reg < centre_reg && centre_reg < hi_reg) ?
                                 centre_reg : ans_reg;
                    state_next = BK_OUTPUT;
                end
                else if (side_reg < S_W'(cfg.win_max) &&
                         (side_reg + S_W'(2)) <= S_W'(MAX_WINDOW))
                begin
                    side_next  = side_reg + S_W'(2);
                    state_next = BK_SETUP;
                end
                else
                begin
                    res_next   = ans_reg;
                    state_next = BK_OUTPUT;
                end
            end

            BK_OUTPUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pipe_vld_reg  <= 1'b0;
            vld_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= (state_reg == BK_SCAN);
            if (clear_win)
            begin
                vld_reg <= '0;
                n_reg   <= '0;
            end
            else if (pipe_vld_reg)
            begin
                vld_reg <= {vld_reg[WIN_N-2:0], 1'b1};
                n_reg   <= n_reg + CNT_W'(1);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        centre_reg   <= centre_next;
        side_reg     <= side_next;
        r1_reg       <= r1_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        ii_reg       <= ii_next;
        jj_reg       <= jj_next;
        row_addr_reg <= row_addr_next;
        cur_addr_reg <= cur_addr_next;
        back_reg     <= back_next;
        le_reg       <= le_next;
        ans_reg      <= ans_next;
        bit_reg      <= bit_next;
        phase_reg    <= phase_next;
        res_reg      <= res_next;
        if (clear_win)
        begin
            lo_reg <= '1;
            hi_reg <= '0;
        end
        else if (pipe_vld_reg)
        begin
            vals_reg[0] <= rd_data;
            for (int k = 1; k < WIN_N; k++)
                vals_reg[k] <= vals_reg[k-1];
            if (rd_data < lo_reg)
                lo_reg <= rd_data;
            if (rd_data > hi_reg)
                hi_reg <= rd_data;
        end
        if (load_out)
        begin
            out_data_reg <= res_next;
            out_last_reg <= job_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The valid flags of the window always agree with its pixel count.
    a_win_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) == int'(n_reg))
        else $error("window valid flags disagree with pixel count");

    // A decision is never taken on an empty window.
    a_win_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DECIDE) |-> (n_reg != '0))
        else $error("decision on an empty window");

endmodule

// ===== sv/adaptive_median_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter
// Streams 8-bit grey pixels through a line store and emits each pixel after
// adaptive median filtering with a growing, border-clipped window.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tdata: pixel; tuser: command
//  m_*       out        m_tvalid / m_tready  tdata: filtered; tlast: frame_last
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// For each tried window size a job walks back over the window rows above the
// pixel, reads the window's pixels and searches the median; the window starts
// at win_min and grows by two up to win_max or 7x7.
// The single store read port scans one pixel per cycle, and the median is
// searched bit by bit.
// Pushes wait while a job is queued or being filtered; flushes queue up.
// No clearing pass after reset; configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module adaptive_median_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [amf_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    input  logic                             s_tuser,   // [0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [amf_pkg::PIX_W-1:0]        m_tdata,   // [7:0] filtered
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [amf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import amf_pkg::*;

    logic [SIDE_W-1:0] win_min_reg;
    logic [SIDE_W-1:0] win_max_reg;
    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    cfg_t              cfg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              q_push;
    logic              q_pop;
    job_t              push_job;
    job_t              head_job;
    logic              q_full;
    logic              q_empty;
    logic              back_busy;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_min_reg <= SIDE_W'(3);
            win_max_reg <= SIDE_W'(7);
            width_reg   <= GEOM_W'(640);
            height_reg  <= GEOM_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIN_MIN: win_min_reg <= cfg_data[SIDE_W-1:0];
                REG_WIN_MAX: win_max_reg <= cfg_data[SIDE_W-1:0];
                REG_WIDTH:   width_reg   <= cfg_data[GEOM_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_data[GEOM_W-1:0];
                default:     ;
            endcase
        end
    end

    // Geometry clamped to the supported frame size.
    always_comb
    begin
        cfg.win_min = win_min_reg;
        cfg.win_max = win_max_reg;
        if (width_reg == '0)
            cfg.width = POS_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            cfg.width = POS_W'(MAX_WIDTH);
        else
            cfg.width = POS_W'(width_reg);
        if (height_reg == '0)
            cfg.height = POS_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            cfg.height = POS_W'(MAX_HEIGHT);
        else
            cfg.height = POS_W'(height_reg);
    end

    amf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    amf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .back_busy (back_busy)
    );

    amf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    amf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .busy     (back_busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
